FILE: rtl/sto_pkg.sv
// Shared types, constants and time arithmetic for the sorted timeout queue.
`timescale 1ns / 1ps

package sto_pkg;

  localparam int DEPTH = 16;
  localparam int ID_W  = 4;
  localparam int SEC_W = 32;
  localparam int NS_W  = 30;

  localparam logic [NS_W:0] NS_PER_SEC  = 31'd1000000000;
  localparam logic [NS_W:0] NS_TWO_SEC  = 31'd2000000000;
  localparam logic [NS_W-1:0] RES_NS_RESET = 30'd1000000;

  localparam logic CFG_RES_SEC = 1'b0;
  localparam logic CFG_RES_NS  = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ADD_REL = 2'd1,
    OP_ADD_ABS = 2'd2,
    OP_REMOVE  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    KIND_ACCEPTED   = 3'd0,
    KIND_ALREADY    = 3'd1,
    KIND_PAST       = 3'd2,
    KIND_NOT_QUEUED = 3'd3,
    KIND_EXPIRED    = 3'd4,
    KIND_TICK_DONE  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_POP    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [SEC_W-1:0] sec;
    logic [NS_W-1:0]  ns;
  } time_t;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic [SEC_W-1:0] sec;
    logic [NS_W-1:0]  ns;
  } entry_t;

  typedef struct packed {
    cmd_e             op;
    logic [ID_W-1:0]  id;
    logic [SEC_W-1:0] sec;
    logic [NS_W-1:0]  ns;
  } cmd_t;

  typedef struct packed {
    entry_t           head;
    logic             hit;
    logic [SEC_W-1:0] hit_sec;
    logic [NS_W-1:0]  hit_ns;
    logic             full;
  } status_t;

  function automatic time_t time_add(input logic [SEC_W-1:0] a_sec,
                                     input logic [NS_W-1:0]  a_ns,
                                     input logic [SEC_W-1:0] b_sec,
                                     input logic [NS_W-1:0]  b_ns);
    logic [NS_W:0] ns_sum;
    logic [1:0]    carry;
    time_t         r;
    ns_sum = {1'b0, a_ns} + {1'b0, b_ns};
    if (ns_sum >= NS_TWO_SEC) begin
      carry = 2'd2;
      r.ns  = NS_W'(ns_sum - NS_TWO_SEC);
    end else if (ns_sum >= NS_PER_SEC) begin
      carry = 2'd1;
      r.ns  = NS_W'(ns_sum - NS_PER_SEC);
    end else begin
      carry = 2'd0;
      r.ns  = NS_W'(ns_sum);
    end
    r.sec = a_sec + b_sec + SEC_W'(carry);
    return r;
  endfunction

endpackage

FILE: rtl/sto_cell.sv
// One queue cell: holds an entry and shifts it to or from its neighbours.
`timescale 1ns / 1ps

module sto_cell import sto_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cmd_t   cmd_i,
  input  entry_t left_i,
  input  logic   left_after_i,
  input  entry_t right_i,
  input  logic   found_i,
  output entry_t ent_o,
  output logic   after_o,
  output logic   found_o,
  output logic   match_o
);

  logic             valid_q, valid_d;
  logic [ID_W-1:0]  id_q, id_d;
  logic [SEC_W-1:0] sec_q, sec_d;
  logic [NS_W-1:0]  ns_q, ns_d;

  assign ent_o   = '{valid: valid_q, id: id_q, sec: sec_q, ns: ns_q};
  assign after_o = valid_q && ({cmd_i.sec, cmd_i.ns} >= {sec_q, ns_q});
  assign match_o = valid_q && (id_q == cmd_i.id);
  assign found_o = found_i || match_o;

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    sec_d   = sec_q;
    ns_d    = ns_q;
    case (cmd_i.op)
      CMD_INSERT: begin
        if (!after_o) begin
          if (left_after_i) begin
            valid_d = 1'b1;
            id_d    = cmd_i.id;
            sec_d   = cmd_i.sec;
            ns_d    = cmd_i.ns;
          end else begin
            valid_d = left_i.valid;
            id_d    = left_i.id;
            sec_d   = left_i.sec;
            ns_d    = left_i.ns;
          end
        end
      end
      CMD_REMOVE: begin
        if (found_o) begin
          valid_d = right_i.valid;
          id_d    = right_i.id;
          sec_d   = right_i.sec;
          ns_d    = right_i.ns;
        end
      end
      CMD_POP: begin
        valid_d = right_i.valid;
        id_d    = right_i.id;
        sec_d   = right_i.sec;
        ns_d    = right_i.ns;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    sec_q <= sec_d;
    ns_q  <= ns_d;
  end

endmodule

FILE: rtl/sto_chain.sv
// Row of queue cells kept sorted by due time, with head and lookup status.
`timescale 1ns / 1ps

module sto_chain import sto_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  output status_t status_o
);

  entry_t            ent      [DEPTH];
  entry_t            left_ent [DEPTH];
  entry_t            right_ent[DEPTH];
  logic [DEPTH-1:0]  after_v;
  logic [DEPTH-1:0]  left_after_v;
  logic [DEPTH-1:0]  found_in_v;
  logic [DEPTH-1:0]  found_v;
  logic [DEPTH-1:0]  match_v;
  logic [DEPTH-1:0]  valid_v;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_ent[g]     = '0;
      assign left_after_v[g] = 1'b1;
      assign found_in_v[g]   = 1'b0;
    end else begin : g_inner
      assign left_ent[g]     = ent[g-1];
      assign left_after_v[g] = after_v[g-1];
      assign found_in_v[g]   = found_v[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_ent[g] = '0;
    end else begin : g_body
      assign right_ent[g] = ent[g+1];
    end

    sto_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd_i),
      .left_i       (left_ent[g]),
      .left_after_i (left_after_v[g]),
      .right_i      (right_ent[g]),
      .found_i      (found_in_v[g]),
      .ent_o        (ent[g]),
      .after_o      (after_v[g]),
      .found_o      (found_v[g]),
      .match_o      (match_v[g])
    );

    assign valid_v[g] = ent[g].valid;
  end

  always_comb begin
    logic [SEC_W-1:0] hs;
    logic [NS_W-1:0]  hn;
    hs = '0;
    hn = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hs = hs | (ent[i].sec & {SEC_W{match_v[i]}});
      hn = hn | (ent[i].ns & {NS_W{match_v[i]}});
    end
    status_o.head    = ent[0];
    status_o.hit     = found_v[DEPTH-1];
    status_o.hit_sec = hs;
    status_o.hit_ns  = hn;
    status_o.full    = valid_v[DEPTH-1];
  end

  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_v & ~{valid_v[DEPTH-2:0], 1'b1}) == '0)
    else $error("queue valid entries do not form a prefix");

  a_unique_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_v))
    else $error("more than one queue entry holds the same id");

endmodule

FILE: rtl/sorted_timeout_queue.sv
// Top level: request decode, time keeping, result register and queue control.
// Add and remove: the request is registered on acceptance; the result is registered from S_INS
// or S_REM once the output register is free, then the next request is taken. Tick with N entries
// falling due: N expiries, then tick_done, one per cycle while the output does not stall.
// One request is in work at a time; a result waits in the output register.
// Asynchronous active-low reset empties the queue, zeroes the time, restores the resolution.
`timescale 1ns / 1ps

module sorted_timeout_queue import sto_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       opcode_i,
  input  logic [ID_W-1:0]  action_id_i,
  input  logic [SEC_W-1:0] due_sec_i,
  input  logic [NS_W-1:0]  due_nanosec_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       result_kind_o,
  output logic [ID_W-1:0]  result_id_o,
  output logic [SEC_W-1:0] time_sec_o,
  output logic [NS_W-1:0]  time_nanosec_o,
  output logic             last_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [SEC_W-1:0] cfg_data_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_INS   = 2'd1;
  localparam logic [1:0] S_REM   = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [SEC_W-1:0] res_sec_q;
  logic [NS_W-1:0]  res_ns_q;
  logic [SEC_W-1:0] now_sec_q, now_sec_d;
  logic [NS_W-1:0]  now_ns_q, now_ns_d;
  logic [ID_W-1:0]  id_q;
  logic             abs_q;
  logic [SEC_W-1:0] tgt_sec_q;
  logic [NS_W-1:0]  tgt_ns_q;
  logic             hit_q;
  logic [SEC_W-1:0] hit_sec_q;
  logic [NS_W-1:0]  hit_ns_q;

  logic             out_valid_q;
  logic [2:0]       kind_q;
  logic [ID_W-1:0]  rid_q;
  logic [SEC_W-1:0] tsec_q;
  logic [NS_W-1:0]  tns_q;
  logic             last_q;

  logic             in_accept;
  logic             out_free;
  logic             emit;
  kind_e            em_kind;
  logic [ID_W-1:0]  em_id;
  logic [SEC_W-1:0] em_sec;
  logic [NS_W-1:0]  em_ns;
  logic             em_last;

  time_t            add_a, add_b, sum;
  cmd_t             cmd;
  status_t          status;

  logic             later;
  logic             borrow;
  logic [SEC_W-1:0] rem_sec;
  logic [NS_W-1:0]  rem_ns;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  sto_chain u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status)
  );

  always_comb begin
    if (opcode_i == OP_ADD_ABS) begin
      add_a.sec = due_sec_i;
      add_a.ns  = due_nanosec_i;
    end else begin
      add_a.sec = now_sec_q;
      add_a.ns  = now_ns_q;
    end
    case (opcode_i)
      OP_TICK:    add_b = '{sec: res_sec_q, ns: res_ns_q};
      OP_ADD_REL: add_b = '{sec: due_sec_i, ns: due_nanosec_i};
      default:    add_b = '0;
    endcase
    sum = time_add(add_a.sec, add_a.ns, add_b.sec, add_b.ns);
  end

  always_comb begin
    later   = {hit_sec_q, hit_ns_q} > {now_sec_q, now_ns_q};
    borrow  = hit_ns_q < now_ns_q;
    rem_sec = hit_sec_q - now_sec_q - SEC_W'(borrow);
    rem_ns  = borrow ? NS_W'({1'b0, hit_ns_q} + NS_PER_SEC - {1'b0, now_ns_q})
                     : hit_ns_q - now_ns_q;
  end

  always_comb begin
    state_d   = state_q;
    now_sec_d = now_sec_q;
    now_ns_d  = now_ns_q;
    cmd.op    = CMD_NONE;
    cmd.id    = (state_q == S_IDLE) ? action_id_i : id_q;
    cmd.sec   = tgt_sec_q;
    cmd.ns    = tgt_ns_q;
    emit      = 1'b0;
    em_kind   = KIND_ACCEPTED;
    em_id     = id_q;
    em_sec    = '0;
    em_ns     = '0;
    em_last   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (opcode_i)
            OP_TICK: begin
              now_sec_d = sum.sec;
              now_ns_d  = sum.ns;
              state_d   = S_DRAIN;
            end
            OP_ADD_REL, OP_ADD_ABS: begin
              state_d = S_INS;
            end
            OP_REMOVE: begin
              cmd.op  = CMD_REMOVE;
              state_d = S_REM;
            end
            default: begin
            end
          endcase
        end
      end
      S_INS: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          if (status.hit) begin
            em_kind = KIND_ALREADY;
          end else if (abs_q && ({tgt_sec_q, tgt_ns_q} < {now_sec_q, now_ns_q})) begin
            em_kind = KIND_PAST;
          end else if (status.full) begin
            em_kind = KIND_ALREADY;
          end else begin
            cmd.op = CMD_INSERT;
          end
        end
      end
      S_REM: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          if (!hit_q) begin
            em_kind = KIND_NOT_QUEUED;
          end else if (later) begin
            em_sec = rem_sec;
            em_ns  = rem_ns;
          end
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          emit = 1'b1;
          if (status.head.valid &&
              ({now_sec_q, now_ns_q} >= {status.head.sec, status.head.ns})) begin
            cmd.op  = CMD_POP;
            em_kind = KIND_EXPIRED;
            em_id   = status.head.id;
            em_last = 1'b0;
          end else begin
            em_kind = KIND_TICK_DONE;
            em_id   = '0;
            em_sec  = now_sec_q;
            em_ns   = now_ns_q;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_sec_q   <= '0;
      now_ns_q    <= '0;
      res_sec_q   <= '0;
      res_ns_q    <= RES_NS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      now_sec_q <= now_sec_d;
      now_ns_q  <= now_ns_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_RES_SEC: res_sec_q <= cfg_data_i;
          CFG_RES_NS:  res_ns_q  <= cfg_data_i[NS_W-1:0];
          default: begin
          end
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      id_q      <= action_id_i;
      abs_q     <= (opcode_i == OP_ADD_ABS);
      tgt_sec_q <= sum.sec;
      tgt_ns_q  <= sum.ns;
      hit_q     <= status.hit;
      hit_sec_q <= status.hit_sec;
      hit_ns_q  <= status.hit_ns;
    end
    if (emit) begin
      kind_q <= em_kind;
      rid_q  <= em_id;
      tsec_q <= em_sec;
      tns_q  <= em_ns;
      last_q <= em_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign result_id_o    = rid_q;
  assign time_sec_o     = tsec_q;
  assign time_nanosec_o = tns_q;
  assign last_o         = last_q;

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == CMD_INSERT) |-> !status.full)
    else $error("insert issued into a full queue");

  a_pop_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == CMD_POP) |-> status.head.valid)
    else $error("pop issued on an empty queue");

  a_done_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && em_kind == KIND_TICK_DONE) |=> (out_valid_o && last_o && result_id_o == '0))
    else $error("tick_done result not closing its request");

endmodule
